FILE: rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the strip chart plotter
// Command and response words, opcodes and the row operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int COUNT_W    = 16;
    localparam int SEL_W      = 4;
    localparam int ROW_OUT_W  = 64;
    localparam int COL_OUT_W  = 6;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_PAGE   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [COUNT_W-1:0] count_value;
        logic [SEL_W-1:0]   row_select;
    } cmd_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row_bits;
        logic [COL_OUT_W-1:0] plot_column;
        logic                 shown_page;
    } rsp_t;

    typedef enum logic [1:0] {
        ROW_ZERO,
        ROW_SHIFT,
        ROW_ERASE,
        ROW_PLOT
    } row_op_t;

endpackage

`default_nettype wire

FILE: rtl/ssc_div.sv
// ----------------------------------------------------------------------------
// ssc_div: quotient by a constant through repeated subtraction
// Subtract DIVIDER once per cycle until the remainder drops below it; a
// dividend at or above HEIGHT*DIVIDER saturates to HEIGHT at once. done
// pulses with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div #(
    parameter int DIVIDER = 2,
    parameter int HEIGHT  = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ssc_pkg::COUNT_W-1:0] dividend,
    output logic                             done,
    output logic [ssc_pkg::COUNT_W-1:0]      quotient
);
    import ssc_pkg::*;

    localparam int LIMIT = HEIGHT * DIVIDER;

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] q_reg, q_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic               ge;

    always_comb
    begin
        ge        = (rem_reg >= COUNT_W'(DIVIDER));
        run_next  = run_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            rem_next = dividend;
            q_next   = '0;
            if (dividend >= COUNT_W'(LIMIT))
            begin
                q_next    = COUNT_W'(HEIGHT);
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
                run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - COUNT_W'(DIVIDER);
                q_next   = q_reg + 1'b1;
            end
            else
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: rtl/ssc_row.sv
// ----------------------------------------------------------------------------
// ssc_row: row update unit
// Shift a row left with zero fill, erase or set one dot, or clear the row.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_row #(
    parameter int WIDTH = 64
) (
    input  wire ssc_pkg::row_op_t           row_op,
    input  wire logic [$clog2(WIDTH)-1:0]   col,
    input  wire logic [WIDTH-1:0]           row_in,
    output logic [WIDTH-1:0]                row_out
);
    import ssc_pkg::*;

    localparam logic [WIDTH-1:0] DOT_LEFT = {1'b1, {(WIDTH-1){1'b0}}};

    logic [WIDTH-1:0] dot;

    always_comb
    begin
        dot = DOT_LEFT >> col;
        unique case (row_op)
            ROW_SHIFT: row_out = row_in << 1;
            ROW_ERASE: row_out = row_in & ~dot;
            ROW_PLOT:  row_out = row_in | dot;
            default:   row_out = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/scrolling_strip_chart_plotter.sv
// ----------------------------------------------------------------------------
// scrolling_strip_chart_plotter: monochrome frame store with a line chart
// Samples plot a scaled count as a dot; a zero count advances the column, scrolling at the right edge.
// ----------------------------------------------------------------------------
// One command word is taken at a time; cmd_stall stays high until its
// response word is loaded. A sample that plots first finds level =
// count/DIVIDER by repeated subtraction (saturating at HEIGHT), then does
// one read-modify-write per touched row through the single-port frame
// memory: erase and plot for a nonzero count, the plot alone for a zero
// count, or all HEIGHT rows and the plot when a zero count scrolls at the
// last column, and then loads its response word. Ignored samples go
// straight to the response. No clearing pass runs after reset.
`default_nettype none

module scrolling_strip_chart_plotter #(
    parameter int WIDTH   = 64,
    parameter int HEIGHT  = 16,
    parameter int DIVIDER = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire ssc_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ssc_pkg::rsp_t      rsp
);
    import ssc_pkg::*;

    localparam int CW  = $clog2(WIDTH);
    localparam int RBW = $clog2(HEIGHT);
    localparam logic [WIDTH-1:0] DOT_LEFT = {1'b1, {(WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_ERASE_RD,
        S_ERASE_WR,
        S_PLOT_RD,
        S_PLOT_WR,
        S_CLEAR,
        S_READ_RD,
        S_READ_WR,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [RBW-1:0]       addr_reg, addr_next;
    logic [RBW-1:0]       tgt_row_reg, tgt_row_next;
    logic [RBW-1:0]       plot_row_reg, plot_row_next;
    logic [CW-1:0]        plot_col_reg, plot_col_next;
    logic [COUNT_W-1:0]   last_count_reg, last_count_next;
    logic                 page_reg, page_next;
    logic [ROW_OUT_W-1:0] bits_reg, bits_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [WIDTH-1:0]     frame_mem [HEIGHT];
    logic [HEIGHT-1:0]    vld_reg;
    logic                 vld_q_reg;
    logic [WIDTH-1:0]     mem_q_reg;
    logic [WIDTH-1:0]     row_rd;
    logic [WIDTH-1:0]     row_wdata;
    logic                 mem_we;
    row_op_t              row_op;

    logic                 div_start;
    logic                 div_done;
    logic [COUNT_W-1:0]   div_q;
    logic [RBW-1:0]       level_row;

    ssc_div #(
        .DIVIDER (DIVIDER),
        .HEIGHT  (HEIGHT)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cmd.count_value),
        .done     (div_done),
        .quotient (div_q)
    );

    ssc_row #(
        .WIDTH (WIDTH)
    ) u_row (
        .row_op  (row_op),
        .col     (plot_col_reg),
        .row_in  (row_rd),
        .row_out (row_wdata)
    );

    always_comb
    begin
        if (vld_q_reg)
            row_rd = mem_q_reg;
        else if (addr_reg == RBW'(HEIGHT - 1))
            row_rd = DOT_LEFT;
        else
            row_rd = '0;

        if (div_q >= COUNT_W'(HEIGHT))
            level_row = '0;
        else
            level_row = RBW'(HEIGHT - 1) - RBW'(div_q);

        mem_we = (state_reg == S_SCROLL_WR) || (state_reg == S_ERASE_WR) ||
                 (state_reg == S_PLOT_WR) || (state_reg == S_CLEAR);

        unique case (state_reg)
            S_SCROLL_WR: row_op = ROW_SHIFT;
            S_ERASE_WR:  row_op = ROW_ERASE;
            S_PLOT_WR:   row_op = ROW_PLOT;
            default:     row_op = ROW_ZERO;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        tgt_row_next    = tgt_row_reg;
        plot_row_next   = plot_row_reg;
        plot_col_next   = plot_col_reg;
        last_count_next = last_count_reg;
        page_next       = page_reg;
        bits_next       = bits_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    bits_next  = '0;
                    state_next = S_DONE;
                    unique case (cmd.opcode)
                        OP_SAMPLE:
                        begin
                            if (!page_reg && cmd.count_value != last_count_reg)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        OP_PAGE:
                        begin
                            page_next     = ~page_reg;
                            plot_col_next = '0;
                            addr_next     = '0;
                            state_next    = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            if (cmd.row_select < HEIGHT)
                            begin
                                addr_next  = RBW'(cmd.row_select);
                                state_next = S_READ_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    last_count_next = cmd_reg.count_value;
                    tgt_row_next    = level_row;
                    if (cmd_reg.count_value == '0)
                    begin
                        if (plot_col_reg < CW'(WIDTH - 1))
                        begin
                            plot_col_next = plot_col_reg + 1'b1;
                            addr_next     = level_row;
                            state_next    = S_PLOT_RD;
                        end
                        else
                        begin
                            addr_next  = '0;
                            state_next = S_SCROLL_RD;
                        end
                    end
                    else
                    begin
                        addr_next  = plot_row_reg;
                        state_next = S_ERASE_RD;
                    end
                end
            end
            S_SCROLL_RD:
            begin
                state_next = S_SCROLL_WR;
            end
            S_SCROLL_WR:
            begin
                if (addr_reg == RBW'(HEIGHT - 1))
                begin
                    addr_next  = tgt_row_reg;
                    state_next = S_PLOT_RD;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_SCROLL_RD;
                end
            end
            S_ERASE_RD:
            begin
                state_next = S_ERASE_WR;
            end
            S_ERASE_WR:
            begin
                addr_next  = tgt_row_reg;
                state_next = S_PLOT_RD;
            end
            S_PLOT_RD:
            begin
                plot_row_next = addr_reg;
                state_next    = S_PLOT_WR;
            end
            S_PLOT_WR:
            begin
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                if (addr_reg == RBW'(HEIGHT - 1))
                    state_next = S_DONE;
                else
                    addr_next = addr_reg + 1'b1;
            end
            S_READ_RD:
            begin
                state_next = S_READ_WR;
            end
            S_READ_WR:
            begin
                bits_next  = ROW_OUT_W'(row_rd) << (ROW_OUT_W - WIDTH);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.row_bits    = bits_reg;
                    rsp_next.plot_column = COL_OUT_W'(plot_col_reg);
                    rsp_next.shown_page  = page_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            tgt_row_reg    <= '0;
            plot_row_reg   <= '0;
            plot_col_reg   <= '0;
            last_count_reg <= '0;
            page_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            tgt_row_reg    <= tgt_row_next;
            plot_row_reg   <= plot_row_next;
            plot_col_reg   <= plot_col_next;
            last_count_reg <= last_count_next;
            page_reg       <= page_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        bits_reg <= bits_next;
        rsp_reg  <= rsp_next;
    end

    // Frame memory: one port, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[addr_reg] <= row_wdata;
        mem_q_reg <= frame_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[addr_reg] <= 1'b1;
            vld_q_reg <= vld_reg[addr_reg];
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_page_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        page_reg |=> $stable(last_count_reg))
        else $error("last count changed on blank page");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(plot_col_reg) |->
            (plot_col_reg == '0 || plot_col_reg == $past(plot_col_reg) + 1'b1))
        else $error("plot column jumped");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (addr_reg < HEIGHT))
        else $error("frame write outside rows");

endmodule

`default_nettype wire
